>>> hw/rtl/adri_pkg.sv
package adri_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int PTR_W       = 28;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;
    localparam int WINDOW_SIZE = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam int SHADOW_N    = 8;
    localparam int VOICE_N     = 4;
    // bytes 1..5 of a voice block: pointer high/mid/low, length high/low
    localparam int RELOAD_BYTES = 5;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [PTR_W-1:0]  ptr_t;

    localparam byte_t OFS_DMACONR  = 8'h02;
    localparam byte_t OFS_POSITION = 8'h06;
    localparam byte_t OFS_ADKCONR  = 8'h10;
    localparam byte_t OFS_INTENAR  = 8'h1C;
    localparam byte_t OFS_INTREQR  = 8'h1E;
    localparam byte_t OFS_DMACON   = 8'h96;
    localparam byte_t OFS_INTENA   = 8'h9A;
    localparam byte_t OFS_INTREQ   = 8'h9C;
    localparam byte_t OFS_ADKCON   = 8'h9E;
    localparam byte_t VOICE_BASE   = 8'hA0;

    localparam int SET_BIT        = 15;
    localparam int DMA_MASTER_BIT = 9;
    localparam int IRQ_MASTER_BIT = 14;
    localparam int IRQ_VOICE_LSB  = 7;

    typedef enum logic [1:0] {
        CMD_RD_BYTE = 2'd0,
        CMD_RD_WORD = 2'd1,
        CMD_WR_BYTE = 2'd2,
        CMD_WR_WORD = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_RD_POS,
        OP_RD_BYTE,
        OP_RD_STATUS,
        OP_RD_WORD,
        OP_WR_BYTE,
        OP_WR_WORD
    } op_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_DMA,
        SEL_INTENA,
        SEL_INTREQ,
        SEL_ADK
    } sel_t;

    typedef struct packed {
        op_t   op;
        sel_t  sel;
        byte_t addr;
        word_t data;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_WR_LO,
        ST_RL_READ,
        ST_RL_CALC,
        ST_EMIT
    } back_state_t;

endpackage

>>> hw/rtl/adri_front.sv
module adri_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // command [1:0], address [9:2], write_data [25:10], zero fill above
    input  logic [adri_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                push_valid,
    input  logic                                push_ready,
    output adri_pkg::item_t                     push_item
);

    adri_pkg::byte_t addr;
    adri_pkg::sel_t  rd_sel;
    adri_pkg::sel_t  wr_sel;

    assign addr       = s_tdata[9:2];
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

    // status registers readable as whole words
    always_comb begin
        case (addr)
            adri_pkg::OFS_DMACONR: rd_sel = adri_pkg::SEL_DMA;
            adri_pkg::OFS_INTENAR: rd_sel = adri_pkg::SEL_INTENA;
            adri_pkg::OFS_INTREQR: rd_sel = adri_pkg::SEL_INTREQ;
            adri_pkg::OFS_ADKCONR: rd_sel = adri_pkg::SEL_ADK;
            default:               rd_sel = adri_pkg::SEL_NONE;
        endcase
    end

    // set/clear registers
    always_comb begin
        case (addr)
            adri_pkg::OFS_DMACON: wr_sel = adri_pkg::SEL_DMA;
            adri_pkg::OFS_INTENA: wr_sel = adri_pkg::SEL_INTENA;
            adri_pkg::OFS_INTREQ: wr_sel = adri_pkg::SEL_INTREQ;
            adri_pkg::OFS_ADKCON: wr_sel = adri_pkg::SEL_ADK;
            default:              wr_sel = adri_pkg::SEL_NONE;
        endcase
    end

    always_comb begin
        push_item.addr = addr;
        push_item.data = s_tdata[25:10];
        push_item.sel  = adri_pkg::SEL_NONE;
        push_item.op   = adri_pkg::OP_WR_BYTE;
        case (adri_pkg::cmd_t'(s_tdata[1:0]))
            adri_pkg::CMD_RD_BYTE: begin
                push_item.op = (addr == adri_pkg::OFS_POSITION) ? adri_pkg::OP_RD_POS
                                                                : adri_pkg::OP_RD_BYTE;
            end
            adri_pkg::CMD_RD_WORD: begin
                push_item.sel = rd_sel;
                push_item.op  = (rd_sel != adri_pkg::SEL_NONE) ? adri_pkg::OP_RD_STATUS
                                                              : adri_pkg::OP_RD_WORD;
            end
            adri_pkg::CMD_WR_BYTE: begin
                push_item.op = adri_pkg::OP_WR_BYTE;
            end
            adri_pkg::CMD_WR_WORD: begin
                push_item.op  = adri_pkg::OP_WR_WORD;
                push_item.sel = wr_sel;
            end
            default: begin
                push_item.op = adri_pkg::OP_WR_BYTE;
            end
        endcase
    end

endmodule

>>> hw/rtl/adri_queue.sv
module adri_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  adri_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output adri_pkg::item_t pop_item
);

    localparam int Depth = adri_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    adri_pkg::item_t q_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = q_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/adri_back.sv
module adri_back #(
    parameter int POINTER_FRACTION_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  adri_pkg::item_t                     pop_item,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [adri_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int WideW = adri_pkg::PTR_W + 16;
    localparam int Win   = adri_pkg::WINDOW_SIZE;
    localparam int PadW  = adri_pkg::OUT_TDATA_W - 2 * adri_pkg::PTR_W - 18;

    // {hit, slot} for the bytes that mirror the status registers
    function automatic logic [3:0] shadow_slot(input adri_pkg::byte_t a);
        logic [3:0] r;
        case (a)
            adri_pkg::OFS_DMACONR:         r = 4'b1000;
            adri_pkg::OFS_DMACONR + 8'd1:  r = 4'b1001;
            adri_pkg::OFS_INTENAR:         r = 4'b1010;
            adri_pkg::OFS_INTENAR + 8'd1:  r = 4'b1011;
            adri_pkg::OFS_INTREQR:         r = 4'b1100;
            adri_pkg::OFS_INTREQR + 8'd1:  r = 4'b1101;
            adri_pkg::OFS_ADKCONR:         r = 4'b1110;
            adri_pkg::OFS_ADKCONR + 8'd1:  r = 4'b1111;
            default:                       r = 4'b0000;
        endcase
        return r;
    endfunction

    function automatic logic [14:0] set_clear(input logic [14:0] old, input adri_pkg::word_t v);
        return v[adri_pkg::SET_BIT] ? (old | v[14:0]) : (old & ~v[14:0]);
    endfunction

    function automatic logic [3:0] dma_active(input logic [14:0] d);
        return d[adri_pkg::DMA_MASTER_BIT] ? d[3:0] : 4'b0000;
    endfunction

    function automatic logic [1:0] lowest_voice(input logic [3:0] m);
        logic [1:0] r;
        if (m[0]) r = 2'd0;
        else if (m[1]) r = 2'd1;
        else if (m[2]) r = 2'd2;
        else r = 2'd3;
        return r;
    endfunction

    adri_pkg::back_state_t state_reg, state_next;

    // byte window
    adri_pkg::byte_t mem [Win];
    adri_pkg::byte_t mem_q_reg;
    logic            vld_q_reg;
    logic [Win-1:0]  vld_reg;
    adri_pkg::byte_t shadow_reg [adri_pkg::SHADOW_N];
    adri_pkg::byte_t pos_reg;

    // set/clear registers
    logic [14:0] dma_reg;
    logic [14:0] ie_reg;
    logic [15:0] ireq_reg;
    logic [14:0] adk_reg;

    // current access
    adri_pkg::op_t   op_reg;
    adri_pkg::byte_t addr_reg;
    adri_pkg::word_t data_reg;
    adri_pkg::byte_t hi_reg;
    logic [3:0]      mask_reg;
    logic [1:0]      voice_reg;
    logic [2:0]      cnt_reg;
    adri_pkg::byte_t pb_reg [adri_pkg::RELOAD_BYTES];

    // pending result
    adri_pkg::word_t res_rd_reg;
    logic            res_reload_reg;
    logic [1:0]      res_voice_reg;
    adri_pkg::ptr_t  res_start_reg;
    adri_pkg::ptr_t  res_end_reg;
    logic            res_last_reg;

    // output register
    logic                               out_valid_reg;
    logic [adri_pkg::OUT_TDATA_W-1:0]   out_data_reg;
    logic                               out_user_reg;
    logic                               out_last_reg;

    logic            out_free;
    logic            take;
    logic            load_out;
    logic            wr_en;
    adri_pkg::byte_t wr_addr;
    adri_pkg::byte_t wr_byte;
    adri_pkg::byte_t rd_addr;
    adri_pkg::byte_t fetch_addr;
    adri_pkg::byte_t fetched;
    adri_pkg::byte_t mem_byte;
    logic [3:0]      fetch_slot;
    logic [3:0]      wr_slot;
    adri_pkg::byte_t status_byte [adri_pkg::SHADOW_N];
    adri_pkg::word_t status_word;

    logic [14:0]     dma_sc;
    logic [3:0]      dma_mask;
    logic [3:0]      irq_en;
    logic [3:0]      denied;

    logic [18:0]     ptr_masked;
    logic [16:0]     len_full;
    logic [WideW-1:0] start_wide;
    logic [WideW-1:0] len_wide;
    adri_pkg::ptr_t  start_ptr;
    adri_pkg::ptr_t  end_ptr;
    logic [3:0]      mask_left;

    assign out_free = !out_valid_reg || m_tready;
    assign take     = pop_valid && pop_ready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // fresh status bytes, high byte carries 7 bits
    assign status_byte[0] = {1'b0, dma_reg[14:8]};
    assign status_byte[1] = dma_reg[7:0];
    assign status_byte[2] = {1'b0, ie_reg[14:8]};
    assign status_byte[3] = ie_reg[7:0];
    assign status_byte[4] = {1'b0, ireq_reg[14:8]};
    assign status_byte[5] = ireq_reg[7:0];
    assign status_byte[6] = {1'b0, adk_reg[14:8]};
    assign status_byte[7] = adk_reg[7:0];

    always_comb begin
        case (pop_item.sel)
            adri_pkg::SEL_DMA:    status_word = {1'b0, dma_reg};
            adri_pkg::SEL_INTENA: status_word = {1'b0, ie_reg};
            adri_pkg::SEL_INTREQ: status_word = {1'b0, ireq_reg[14:0]};
            adri_pkg::SEL_ADK:    status_word = {1'b0, adk_reg};
            default:              status_word = '0;
        endcase
    end

    // a byte read lands in the cycle after its address
    assign mem_byte   = vld_q_reg ? mem_q_reg : '0;
    assign fetch_addr = (state_reg == adri_pkg::ST_FETCH_LO) ? addr_reg + 8'd1 : addr_reg;
    assign fetch_slot = shadow_slot(fetch_addr);
    always_comb begin
        if (fetch_slot[3]) begin
            fetched = shadow_reg[fetch_slot[2:0]];
        end else if (fetch_addr == adri_pkg::OFS_POSITION) begin
            fetched = pos_reg;
        end else begin
            fetched = mem_byte;
        end
    end

    // set/clear side effects of a word write
    assign dma_sc   = set_clear(dma_reg, pop_item.data);
    assign dma_mask = dma_active(dma_sc) & ~dma_active(dma_reg);
    assign irq_en   = ie_reg[adri_pkg::IRQ_MASTER_BIT] ?
                      ie_reg[adri_pkg::IRQ_VOICE_LSB +: 4] : 4'b0000;
    assign denied   = (~irq_en | ireq_reg[adri_pkg::IRQ_VOICE_LSB +: 4]) &
                      pop_item.data[adri_pkg::IRQ_VOICE_LSB +: 4];

    // pointer reload arithmetic
    assign ptr_masked = {pb_reg[0][2:0], pb_reg[1], pb_reg[2][7:1], 1'b0};
    assign len_full   = ({pb_reg[3], pb_reg[4]} == 16'h0000) ? 17'h10000
                                                             : {1'b0, pb_reg[3], pb_reg[4]};
    assign start_wide = WideW'(ptr_masked) << POINTER_FRACTION_BITS;
    assign len_wide   = WideW'(len_full) << (POINTER_FRACTION_BITS + 1);
    assign start_ptr  = start_wide[adri_pkg::PTR_W-1:0];
    assign end_ptr    = start_ptr + len_wide[adri_pkg::PTR_W-1:0];
    assign mask_left  = mask_reg & ~(4'b0001 << voice_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            adri_pkg::ST_IDLE: begin
                if (pop_valid) begin
                    case (pop_item.op)
                        adri_pkg::OP_RD_BYTE,
                        adri_pkg::OP_RD_WORD: state_next = adri_pkg::ST_FETCH_HI;
                        adri_pkg::OP_WR_WORD: state_next = adri_pkg::ST_WR_LO;
                        default:              state_next = adri_pkg::ST_EMIT;
                    endcase
                end
            end
            adri_pkg::ST_FETCH_HI: begin
                state_next = (op_reg == adri_pkg::OP_RD_WORD) ? adri_pkg::ST_FETCH_LO
                                                             : adri_pkg::ST_EMIT;
            end
            adri_pkg::ST_FETCH_LO: state_next = adri_pkg::ST_EMIT;
            adri_pkg::ST_WR_LO: begin
                state_next = (mask_reg == 4'b0000) ? adri_pkg::ST_EMIT : adri_pkg::ST_RL_READ;
            end
            adri_pkg::ST_RL_READ: begin
                if (cnt_reg == 3'(adri_pkg::RELOAD_BYTES)) begin
                    state_next = adri_pkg::ST_RL_CALC;
                end
            end
            adri_pkg::ST_RL_CALC: state_next = adri_pkg::ST_EMIT;
            adri_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = res_last_reg ? adri_pkg::ST_IDLE : adri_pkg::ST_RL_READ;
                end
            end
            default: state_next = adri_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop_ready = 1'b0;
        load_out  = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = addr_reg;
        wr_byte   = data_reg[7:0];
        rd_addr   = addr_reg;
        case (state_reg)
            adri_pkg::ST_IDLE: begin
                pop_ready = 1'b1;
                rd_addr   = pop_item.addr;
                wr_addr   = pop_item.addr;
                wr_byte   = (pop_item.op == adri_pkg::OP_WR_WORD) ? pop_item.data[15:8]
                                                                  : pop_item.data[7:0];
                wr_en     = pop_valid && (pop_item.op == adri_pkg::OP_WR_BYTE ||
                                          pop_item.op == adri_pkg::OP_WR_WORD);
            end
            adri_pkg::ST_FETCH_HI: rd_addr = addr_reg + 8'd1;
            adri_pkg::ST_WR_LO: begin
                wr_en   = 1'b1;
                wr_addr = addr_reg + 8'd1;
                wr_byte = data_reg[7:0];
            end
            adri_pkg::ST_RL_READ: begin
                rd_addr = adri_pkg::VOICE_BASE + {2'b00, voice_reg, 4'b0000} +
                          {5'b00000, cnt_reg} + 8'd1;
            end
            adri_pkg::ST_EMIT: load_out = out_free;
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    assign wr_slot = shadow_slot(wr_addr);

    // window memory, bytes outside the status and position slots
    always_ff @(posedge aclk) begin
        if (wr_en && !wr_slot[3] && wr_addr != adri_pkg::OFS_POSITION) begin
            mem[wr_addr] <= wr_byte;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            vld_q_reg <= vld_reg[rd_addr];
            if (wr_en && !wr_slot[3] && wr_addr != adri_pkg::OFS_POSITION) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // control and architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= adri_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            dma_reg       <= '0;
            ie_reg        <= '0;
            ireq_reg      <= '0;
            adk_reg       <= '0;
            pos_reg       <= '0;
            mask_reg      <= '0;
            for (int i = 0; i < adri_pkg::SHADOW_N; i++) begin
                shadow_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (wr_en) begin
                if (wr_slot[3]) begin
                    shadow_reg[wr_slot[2:0]] <= wr_byte;
                end else if (wr_addr == adri_pkg::OFS_POSITION) begin
                    pos_reg <= wr_byte;
                end
            end

            if (take) begin
                if (pop_item.op == adri_pkg::OP_RD_POS) begin
                    pos_reg <= pos_reg + 8'd1;
                end
                if (pop_item.op == adri_pkg::OP_RD_BYTE) begin
                    for (int i = 0; i < adri_pkg::SHADOW_N; i++) begin
                        shadow_reg[i] <= status_byte[i];
                    end
                end
                if (pop_item.op == adri_pkg::OP_WR_WORD) begin
                    case (pop_item.sel)
                        adri_pkg::SEL_DMA: begin
                            dma_reg  <= dma_sc;
                            mask_reg <= dma_mask;
                        end
                        adri_pkg::SEL_INTENA: begin
                            ie_reg   <= set_clear(ie_reg, pop_item.data);
                            mask_reg <= '0;
                        end
                        adri_pkg::SEL_ADK: begin
                            adk_reg  <= set_clear(adk_reg, pop_item.data);
                            mask_reg <= '0;
                        end
                        adri_pkg::SEL_INTREQ: begin
                            if (pop_item.data[adri_pkg::SET_BIT]) begin
                                ireq_reg <= ireq_reg | pop_item.data;
                                mask_reg <= denied;
                            end else begin
                                ireq_reg <= ireq_reg & ~pop_item.data;
                                mask_reg <= '0;
                            end
                        end
                        default: begin
                            mask_reg <= '0;
                        end
                    endcase
                end else begin
                    mask_reg <= '0;
                end
            end

            if (state_reg == adri_pkg::ST_RL_CALC) begin
                mask_reg <= mask_left;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (take) begin
            op_reg         <= pop_item.op;
            addr_reg       <= pop_item.addr;
            data_reg       <= pop_item.data;
            res_reload_reg <= 1'b0;
            res_voice_reg  <= '0;
            res_start_reg  <= '0;
            res_end_reg    <= '0;
            res_last_reg   <= 1'b1;
            case (pop_item.op)
                adri_pkg::OP_RD_POS:    res_rd_reg <= {8'h00, pos_reg};
                adri_pkg::OP_RD_STATUS: res_rd_reg <= status_word;
                default:                res_rd_reg <= '0;
            endcase
        end

        case (state_reg)
            adri_pkg::ST_FETCH_HI: begin
                hi_reg     <= fetched;
                res_rd_reg <= {8'h00, fetched};
            end
            adri_pkg::ST_FETCH_LO: res_rd_reg <= {hi_reg, fetched};
            // pick the next voice to reload
            adri_pkg::ST_WR_LO,
            adri_pkg::ST_EMIT: begin
                voice_reg <= lowest_voice(mask_reg);
                cnt_reg   <= '0;
            end
            adri_pkg::ST_RL_READ: begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg != 3'd0) begin
                    pb_reg[3'(cnt_reg - 3'd1)] <= mem_byte;
                end
            end
            adri_pkg::ST_RL_CALC: begin
                res_rd_reg     <= '0;
                res_reload_reg <= 1'b1;
                res_voice_reg  <= voice_reg;
                res_start_reg  <= start_ptr;
                res_end_reg    <= end_ptr;
                res_last_reg   <= (mask_left == 4'b0000);
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase

        if (load_out) begin
            out_data_reg <= {{PadW{1'b0}}, res_end_reg, res_start_reg, res_voice_reg,
                             res_rd_reg};
            out_user_reg <= res_reload_reg;
            out_last_reg <= res_last_reg;
        end
    end

endmodule

>>> hw/rtl/audio_dma_register_interface_top.sv
// channel  | dir | tdata (low bit up)                             | tuser          | tlast
// s_       | in  | command, address, write_data                   | -              | -
// m_       | out | read_data, voice_index, voice_start, voice_end | voice_reloaded | last
//
// byte writes, position byte and status word reads go from idle straight to emit; other
// byte reads pass through fetch_hi, word writes through wr_lo and word reads through
// fetch_hi and fetch_lo; a word write that reloads then reads five bytes per reloaded
// voice through the single read port of the window memory, computes, and emits
// reset clears control state and the per-byte valid bits, so the window reads as zero
// at once; there is no clearing pass
// a two-entry queue sits between decode and execution, and an output register lets the
// next access queue up while a result waits on m_tready
module audio_dma_register_interface_top #(
    parameter int POINTER_FRACTION_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // command [1:0], address [9:2], write_data [25:10], zero fill above
    input  logic [adri_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_data [15:0], voice_index [17:16], voice_start [45:18], voice_end [73:46]
    output logic [adri_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // voice_reloaded
    output logic                                m_tuser,
    output logic                                m_tlast
);

    logic            push_valid;
    logic            push_ready;
    adri_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    adri_pkg::item_t pop_item;

    adri_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    adri_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    adri_back #(
        .POINTER_FRACTION_BITS (POINTER_FRACTION_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
